// ===== hdl/csq_pkg.sv =====
// Shared types, Q14 constants and the CORDIC rotation step for the sine/cosine block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package csq_pkg;

    // Field widths
    localparam int ANGLE_W = 20;            // input angle, signed Q14
    localparam int RES_W   = 16;            // result, signed Q14
    localparam int ACC_W   = ANGLE_W + 1;   // angle after the optional +pi/2
    localparam int MAG_W   = ANGLE_W;       // magnitude of that sum
    localparam int ZW      = 18;            // reduced angle and CORDIC z
    localparam int XYW     = 18;            // CORDIC x and y

    // Rotation count, split over two register stages
    localparam int ITERATIONS = 10;
    localparam int ITER_A     = ITERATIONS / 2;
    localparam int ITER_B     = ITERATIONS - ITER_A;

    // Q14 constants
    localparam int TWO_PI    = 102944;
    localparam int PI_Q      = 51472;
    localparam int HALF_PI   = 25736;
    localparam int START_X   = 9949;
    localparam int SAT_Q     = 16448;
    // |angle + pi/2| never reaches six turns of 2*pi
    localparam int MAX_TURNS = 5;

    localparam int ATAN_Q14 [16] = '{
        12868, 7596, 4014, 2037, 1022, 511, 256, 128,
        64, 32, 16, 8, 4, 2, 1, 1
    };

    typedef struct packed {
        logic                      valid;
        logic signed [ANGLE_W-1:0] angle_q14;
        logic                      want_cosine;
    } ang_beat_t;

    typedef struct packed {
        logic                 valid;
        logic signed [ZW-1:0] z;
    } z_beat_t;

    typedef struct packed {
        logic                    valid;
        logic signed [RES_W-1:0] result_q14;
    } res_beat_t;

    typedef struct packed {
        logic signed [XYW-1:0] x;
        logic signed [XYW-1:0] y;
        logic signed [ZW-1:0]  z;
    } rot_t;

    // One rotation-mode step; shifts are floor (arithmetic) shifts
    function automatic rot_t cordic_rot(input rot_t s, input int i);
        logic signed [XYW-1:0] dx;
        logic signed [XYW-1:0] dy;
        logic signed [ZW-1:0]  ang;
        rot_t                  r;
        dx  = s.y >>> i;
        dy  = s.x >>> i;
        ang = ZW'(ATAN_Q14[i]);
        if (s.z >= 0) begin
            r.x = s.x - dx;
            r.y = s.y + dy;
            r.z = s.z - ang;
        end else begin
            r.x = s.x + dx;
            r.y = s.y - dy;
            r.z = s.z + ang;
        end
        return r;
    endfunction

endpackage

// ===== hdl/csq_reduce.sv =====
// Range reduction: optional +pi/2, truncated remainder by 2*pi, folds into [-pi/2, pi/2].
// Two register stages with per-stage flow control. Depends on csq_pkg.
`timescale 1ns / 1ps

module csq_reduce (
    input  logic              aclk,
    input  logic              aresetn,
    input  csq_pkg::ang_beat_t in_beat,
    output logic              in_ready,
    output csq_pkg::z_beat_t  out_beat,
    input  logic              out_ready
);
    import csq_pkg::*;

    z_beat_t              rem_reg;
    z_beat_t              rem_next;
    z_beat_t              z_reg;
    z_beat_t              z_next;
    logic                 rem_en;
    logic                 z_en;

    logic signed [ACC_W-1:0] acc;
    logic                    neg;
    logic [MAG_W-1:0]        mag;
    logic [MAG_W-1:0]        turns_sub;
    logic [MAG_W-1:0]        rem_u;
    logic signed [ZW-1:0]    f;

    assign z_en     = !z_reg.valid || out_ready;
    assign rem_en   = !rem_reg.valid || z_en;
    assign in_ready = rem_en;
    assign out_beat = z_reg;

    // stage 1: remainder keeps the sign of the dividend
    always_comb begin
        acc = {in_beat.angle_q14[ANGLE_W-1], in_beat.angle_q14}
            + (in_beat.want_cosine ? ACC_W'(HALF_PI) : ACC_W'(0));
        neg = acc[ACC_W-1];
        mag = neg ? MAG_W'(-acc) : MAG_W'(acc);
        turns_sub = '0;
        for (int n = 1; n <= MAX_TURNS; n++) begin
            if (mag >= MAG_W'(n * TWO_PI)) begin
                turns_sub = MAG_W'(n * TWO_PI);
            end
        end
        rem_u = mag - turns_sub;
        rem_next.valid = in_beat.valid;
        rem_next.z     = neg ? -ZW'(rem_u) : ZW'(rem_u);
    end

    // stage 2: fold into [-pi, pi], then reflect about +-pi/2
    always_comb begin
        f = rem_reg.z;
        if (f > PI_Q) begin
            f = ZW'(f - TWO_PI);
        end else if (f < -PI_Q) begin
            f = ZW'(f + TWO_PI);
        end
        if (f > HALF_PI) begin
            f = ZW'(PI_Q - f);
        end else if (f < -HALF_PI) begin
            f = ZW'(-PI_Q - f);
        end
        z_next.valid = rem_reg.valid;
        z_next.z     = f;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg.valid <= 1'b0;
            z_reg.valid   <= 1'b0;
        end else begin
            if (rem_en) begin
                rem_reg <= rem_next;
            end
            if (z_en) begin
                z_reg <= z_next;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg.valid |-> (rem_reg.z < TWO_PI && rem_reg.z > -TWO_PI))
        else $error("remainder outside one turn");

    assert property (@(posedge aclk) disable iff (!aresetn)
        z_reg.valid |-> (z_reg.z <= HALF_PI && z_reg.z >= -HALF_PI))
        else $error("folded angle outside [-pi/2, pi/2]");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_reg.valid && !rem_en) |=> (rem_reg.valid && $stable(rem_reg.z)))
        else $error("stalled remainder stage lost its beat");

endmodule

// ===== hdl/csq_cordic.sv =====
// Rotation-mode CORDIC in two register stages, then saturation of y into the result.
// Depends on csq_pkg (step function, arctangent table, constants).
`timescale 1ns / 1ps

module csq_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  csq_pkg::z_beat_t   in_beat,
    output logic               in_ready,
    output csq_pkg::res_beat_t out_beat,
    input  logic               out_ready
);
    import csq_pkg::*;

    rot_t      mid_reg;
    rot_t      mid_next;
    logic      mid_valid_reg;
    res_beat_t res_reg;
    res_beat_t res_next;
    logic      mid_en;
    logic      res_en;
    rot_t      fin;

    assign res_en   = !res_reg.valid || out_ready;
    assign mid_en   = !mid_valid_reg || res_en;
    assign in_ready = mid_en;
    assign out_beat = res_reg;

    // first half of the rotations
    always_comb begin
        mid_next.x = XYW'(START_X);
        mid_next.y = '0;
        mid_next.z = in_beat.z;
        for (int i = 0; i < ITER_A; i++) begin
            mid_next = cordic_rot(mid_next, i);
        end
    end

    // second half, then clamp
    always_comb begin
        fin = mid_reg;
        for (int i = ITER_A; i < ITERATIONS; i++) begin
            fin = cordic_rot(fin, i);
        end
        res_next.valid = mid_valid_reg;
        if (fin.y > SAT_Q) begin
            res_next.result_q14 = RES_W'(SAT_Q);
        end else if (fin.y < -SAT_Q) begin
            res_next.result_q14 = RES_W'(-SAT_Q);
        end else begin
            res_next.result_q14 = RES_W'(fin.y);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            res_reg.valid <= 1'b0;
        end else begin
            if (mid_en) begin
                mid_valid_reg <= in_beat.valid;
            end
            if (res_en) begin
                res_reg.valid <= res_next.valid;
            end
        end
        if (res_en) begin
            res_reg.result_q14 <= res_next.result_q14;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_en) begin
            mid_reg <= mid_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        res_reg.valid |-> (res_reg.result_q14 <= SAT_Q && res_reg.result_q14 >= -SAT_Q))
        else $error("result outside saturation range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        mid_valid_reg |-> (mid_reg.x > 0))
        else $error("CORDIC x went non-positive mid-way");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_reg.valid && !out_ready && mid_valid_reg) |=> mid_valid_reg)
        else $error("mid stage dropped a beat under stall");

endmodule

// ===== hdl/cordic_sine_cosine_q14.sv =====
// Top level of the Q14 CORDIC sine/cosine block: input register, range reduction,
// CORDIC rotations. Depends on csq_pkg, csq_reduce and csq_cordic.
`timescale 1ns / 1ps

// Usage
//   s_ channel: one beat per angle. s_tdata[19:0] is the angle in radians,
//   signed Q14 (16384 = 1.0); s_tuser picks cosine (1) or sine (0).
//   m_ channel: one beat per input beat, in order. m_tdata is sin or cos in
//   signed Q14, clamped to +-16448.
//   Path: an accepted beat passes the input register, remainder and fold
//   registers and two CORDIC stages of five rotations each before m_tvalid
//   rises.
//   Throughput: one beat per cycle; every stage is a register with its own
//   valid bit, so the pipe takes a new beat each cycle while m_tready holds.
//   Stall: with m_tready low the result register holds its beat; earlier
//   stages keep filling their empty slots, and s_tready falls only once
//   all five stages hold a beat.
//   Reset (aresetn low, synchronous): all valid bits clear, no beat is in
//   flight; there is no other state.
//   No configuration registers.
module cordic_sine_cosine_q14 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [19:0] angle_q14, [23:20] zero
    input  logic        s_tuser,   // [0] want_cosine
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] result_q14
);
    import csq_pkg::*;

    ang_beat_t in_reg;
    ang_beat_t in_next;
    logic      in_en;
    logic      red_ready;
    z_beat_t   red_beat;
    logic      cor_ready;
    res_beat_t res_beat;

    // input register
    assign in_en    = !in_reg.valid || red_ready;
    assign s_tready = in_en;

    always_comb begin
        in_next.valid       = s_tvalid;
        in_next.angle_q14   = s_tdata[ANGLE_W-1:0];
        in_next.want_cosine = s_tuser;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg.valid <= 1'b0;
        end else if (in_en) begin
            in_reg.valid <= in_next.valid;
        end
        if (in_en) begin
            in_reg.angle_q14   <= in_next.angle_q14;
            in_reg.want_cosine <= in_next.want_cosine;
        end
    end

    csq_reduce u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_beat   (in_reg),
        .in_ready  (red_ready),
        .out_beat  (red_beat),
        .out_ready (cor_ready)
    );

    csq_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_beat   (red_beat),
        .in_ready  (cor_ready),
        .out_beat  (res_beat),
        .out_ready (m_tready)
    );

    assign m_tvalid = res_beat.valid;
    assign m_tdata  = res_beat.result_q14;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_reg.valid && !in_en) |=> (in_reg.valid && $stable(in_reg.angle_q14)))
        else $error("input register lost a stalled beat");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready) |-> (in_reg.valid && red_beat.valid && m_tvalid && !m_tready))
        else $error("input stalled while the pipe still had room");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_reg.valid)
        else $error("accepted beat not captured");

endmodule
